// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the column engine modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is low.
`define BCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check, active in every cycle.
`define BCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bcc_pkg.sv -----
// ---------------------------------------------------------------------------
// bcc_pkg
// Types, codes and widths shared by the banded Cholesky column engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcc_pkg;

  localparam int MAX_SIZE_DEF  = 1024;
  localparam int BAND_DEF      = 3;
  localparam int FRAC_BITS_DEF = 16;

  localparam int SIZE_W      = 11;
  localparam int COEF_W      = 8;
  localparam int IDX_W       = 10;
  localparam int VAL_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;
  localparam int STEP_W      = 4;
  localparam int ROW_W       = 2;
  localparam int OPND_W      = 63;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_SIZE        = 3'd0,
    REG_COEF_DIAG          = 3'd1,
    REG_COEF_OFF_ONE       = 3'd2,
    REG_COEF_OFF_TWO       = 3'd3,
    REG_CORNER_SIZE        = 3'd4,
    REG_CORNER_FIRST_DIAG  = 3'd5,
    REG_CORNER_OFF         = 3'd6,
    REG_CORNER_SECOND_DIAG = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]        matrix_size;
    logic signed [COEF_W-1:0] coef_diag;
    logic signed [COEF_W-1:0] coef_off_one;
    logic signed [COEF_W-1:0] coef_off_two;
    logic [1:0]               corner_size;
    logic signed [COEF_W-1:0] corner_first_diag;
    logic signed [COEF_W-1:0] corner_off;
    logic signed [COEF_W-1:0] corner_second_diag;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_START_COL,
    OP_INIT_ROW,
    OP_SUB_MUL2,
    OP_SUB_FINAL,
    OP_START_SQRT,
    OP_START_DIV,
    OP_STORE_ITER,
    OP_NEXT_ROW,
    OP_EMIT_START,
    OP_EMIT,
    OP_COL_END,
    OP_EMIT_DONE
  } op_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_DONE,
    C_OFFDIAG,
    C_R_NONPOS,
    C_BAD,
    C_BUSY,
    C_MORE_ROWS,
    C_EMIT_LOOP,
    C_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic col_done;
    logic offdiag;
    logic r_nonpos;
    logic bad;
    logic iter_busy;
    logic more_rows;
    logic emit_loop;
    logic out_blocked;
  } status_t;

  typedef enum logic {
    MODE_SQRT,
    MODE_DIV
  } iter_mode_t;

  typedef struct packed {
    logic              start;
    iter_mode_t        mode;
    logic [OPND_W-1:0] operand;
    logic              neg;
    logic [VAL_W-1:0]  divisor;
  } iter_req_t;

  typedef struct packed {
    logic             busy;
    logic [VAL_W-1:0] result;
  } iter_rsp_t;

endpackage

// ----- rtl/core/banded_cholesky_column_engine_top.sv -----
// ---------------------------------------------------------------------------
// banded_cholesky_column_engine_top
// Column-at-a-time Cholesky factor of a symmetric band matrix, half-bandwidth
// two, with optional corner block, in signed fixed point.
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    tdata[0] restart
//   out_     out  out_tvalid/out_tready  tdata row,col,value; tlast; tuser
//   cfg_     in   cfg_valid/cfg_ready    cfg_index register, cfg_data value
//
// One word in yields up to three factor words; the shared root/divide unit,
// one result bit per cycle, sets the pace.
// A column past the end gives one done word.
// rst_n is synchronous; no clearing pass is needed.
// A stalled out_ holds the engine only when a further word must be loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module banded_cholesky_column_engine_top import bcc_pkg::*; #(
  parameter int MAX_SIZE  = MAX_SIZE_DEF,
  parameter int BAND      = BAND_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] restart, [7:1] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] factor row, [19:10] factor column,
                                             // [51:20] factor_value, [55:52] zero
  output logic                   out_tlast,  // last_of_column
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] pivot_error, [1] done_res
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  op_t       op;
  status_t   status;
  iter_req_t iter_req;
  iter_rsp_t iter_rsp;

  bcc_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  bcc_datapath #(
    .MAX_SIZE  (MAX_SIZE),
    .BAND      (BAND),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .status     (status),
    .iter_req   (iter_req),
    .iter_rsp   (iter_rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  bcc_iter_unit u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .rsp   (iter_rsp)
  );

endmodule

// ----- rtl/core/bcc_sequencer.sv -----
// ---------------------------------------------------------------------------
// bcc_sequencer
// Step counter and control store; issues one control word per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_sequencer import bcc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output op_t     op
);

  localparam logic [STEP_W-1:0] S_TAKE     = 4'd0;
  localparam logic [STEP_W-1:0] S_START    = 4'd1;
  localparam logic [STEP_W-1:0] S_ROW      = 4'd2;
  localparam logic [STEP_W-1:0] S_MUL2     = 4'd3;
  localparam logic [STEP_W-1:0] S_SUBF     = 4'd4;
  localparam logic [STEP_W-1:0] S_SQRT     = 4'd5;
  localparam logic [STEP_W-1:0] S_SQ_WAIT  = 4'd6;
  localparam logic [STEP_W-1:0] S_SQ_JMP   = 4'd7;
  localparam logic [STEP_W-1:0] S_DIV      = 4'd8;
  localparam logic [STEP_W-1:0] S_DIV_WAIT = 4'd9;
  localparam logic [STEP_W-1:0] S_NEXT     = 4'd10;
  localparam logic [STEP_W-1:0] S_EMIT0    = 4'd11;
  localparam logic [STEP_W-1:0] S_EMIT     = 4'd12;
  localparam logic [STEP_W-1:0] S_COL_END  = 4'd13;
  localparam logic [STEP_W-1:0] S_DONE     = 4'd14;
  localparam logic [STEP_W-1:0] S_DONE_JMP = 4'd15;

  function automatic ctrl_word_t rom_word(input logic [STEP_W-1:0] s);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: C_NONE, target: S_TAKE};
    unique case (s)
      S_TAKE:     w = '{op: OP_TAKE,       cond: C_NO_INPUT,    target: S_TAKE};
      S_START:    w = '{op: OP_START_COL,  cond: C_DONE,        target: S_DONE};
      S_ROW:      w = '{op: OP_INIT_ROW,   cond: C_NONE,        target: S_TAKE};
      S_MUL2:     w = '{op: OP_SUB_MUL2,   cond: C_NONE,        target: S_TAKE};
      S_SUBF:     w = '{op: OP_SUB_FINAL,  cond: C_OFFDIAG,     target: S_DIV};
      S_SQRT:     w = '{op: OP_START_SQRT, cond: C_R_NONPOS,    target: S_NEXT};
      S_SQ_WAIT:  w = '{op: OP_STORE_ITER, cond: C_BUSY,        target: S_SQ_WAIT};
      S_SQ_JMP:   w = '{op: OP_NOP,        cond: C_ALWAYS,      target: S_NEXT};
      S_DIV:      w = '{op: OP_START_DIV,  cond: C_BAD,         target: S_NEXT};
      S_DIV_WAIT: w = '{op: OP_STORE_ITER, cond: C_BUSY,        target: S_DIV_WAIT};
      S_NEXT:     w = '{op: OP_NEXT_ROW,   cond: C_MORE_ROWS,   target: S_ROW};
      S_EMIT0:    w = '{op: OP_EMIT_START, cond: C_NONE,        target: S_TAKE};
      S_EMIT:     w = '{op: OP_EMIT,       cond: C_EMIT_LOOP,   target: S_EMIT};
      S_COL_END:  w = '{op: OP_COL_END,    cond: C_ALWAYS,      target: S_TAKE};
      S_DONE:     w = '{op: OP_EMIT_DONE,  cond: C_OUT_BLOCKED, target: S_DONE};
      S_DONE_JMP: w = '{op: OP_NOP,        cond: C_ALWAYS,      target: S_TAKE};
      default:    w = '{op: OP_NOP,        cond: C_ALWAYS,      target: S_TAKE};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] step_r, step_nxt;
  ctrl_word_t        word;
  logic              jump;

  assign word = rom_word(step_r);
  assign op   = word.op;

  always_comb begin
    unique case (word.cond)
      C_NONE:        jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_INPUT:    jump = !status.in_valid;
      C_DONE:        jump = status.col_done;
      C_OFFDIAG:     jump = status.offdiag;
      C_R_NONPOS:    jump = status.r_nonpos;
      C_BAD:         jump = status.bad;
      C_BUSY:        jump = status.iter_busy;
      C_MORE_ROWS:   jump = status.more_rows;
      C_EMIT_LOOP:   jump = status.emit_loop;
      C_OUT_BLOCKED: jump = status.out_blocked;
      default:       jump = 1'b0;
    endcase
    step_nxt = jump ? word.target : step_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_TAKE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- rtl/core/bcc_iter_unit.sv -----
// ---------------------------------------------------------------------------
// bcc_iter_unit
// Shared iterative unit: integer square root, one result bit per step, or
// signed restoring division with saturation, one quotient bit per step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bcc_iter_unit import bcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  iter_req_t req,
  output iter_rsp_t rsp
);

  localparam int CNT_W      = 6;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 33;

  iter_mode_t        mode_r;
  logic              neg_r;
  logic              ovf_r;
  logic [63:0]       acc_r, acc_nxt;
  logic [63:0]       res_r, res_nxt;
  logic [OPND_W-1:0] aux_r, aux_nxt;
  logic [VAL_W-1:0]  div_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [63:0]       sq_trial;
  logic [VAL_W:0]    dv_trial;
  logic [VAL_W:0]    dv_diff;
  logic [VAL_W:0]    quot;
  logic [VAL_W-1:0]  result;

  always_comb begin
    sq_trial = res_r + {1'b0, aux_r};
    dv_trial = {acc_r[VAL_W-1:0], aux_r[OPND_W-1]};
    dv_diff  = dv_trial - {1'b0, div_r};
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    aux_nxt  = aux_r;
    if (mode_r == MODE_SQRT) begin
      if (acc_r >= sq_trial) begin
        acc_nxt = acc_r - sq_trial;
        res_nxt = (res_r >> 1) + {1'b0, aux_r};
      end else begin
        res_nxt = res_r >> 1;
      end
      aux_nxt = aux_r >> 2;
    end else begin
      if (dv_trial >= {1'b0, div_r}) begin
        acc_nxt = {31'b0, dv_diff};
        res_nxt = {res_r[62:0], 1'b1};
      end else begin
        acc_nxt = {31'b0, dv_trial};
        res_nxt = {res_r[62:0], 1'b0};
      end
      aux_nxt = aux_r << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= (req.mode == MODE_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.mode;
      neg_r  <= req.neg;
      div_r  <= req.divisor;
      res_r  <= '0;
      if (req.mode == MODE_SQRT) begin
        acc_r <= {1'b0, req.operand};
        aux_r <= {1'b1, 62'b0};
        ovf_r <= 1'b0;
      end else begin
        acc_r <= {34'b0, req.operand[OPND_W-1:DIV_STEPS]};
        aux_r <= {req.operand[DIV_STEPS-1:0], 30'b0};
        ovf_r <= {2'b0, req.operand[OPND_W-1:DIV_STEPS]} >= req.divisor;
      end
    end else if (cnt_r != '0) begin
      acc_r <= acc_nxt;
      res_r <= res_nxt;
      aux_r <= aux_nxt;
    end
  end

  always_comb begin
    quot = res_r[VAL_W:0];
    if (mode_r == MODE_SQRT) begin
      result = (res_r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : res_r[VAL_W-1:0];
    end else if (neg_r) begin
      result = (ovf_r || quot > 33'h0_8000_0000) ? 32'h8000_0000 : (~quot[VAL_W-1:0] + 32'd1);
    end else begin
      result = (ovf_r || quot > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quot[VAL_W-1:0];
    end
  end

  assign rsp.busy   = (cnt_r != '0);
  assign rsp.result = result;

  `BCC_ASSERT(a_start_idle, clk, rst_n, req.start |-> (cnt_r == '0), "start while unit busy")
  `BCC_ASSERT(a_count_down, clk, rst_n, (cnt_r != '0) |=> (cnt_r == $past(cnt_r) - 6'd1), "step count skipped")

endmodule

// ----- rtl/core/bcc_datapath.sv -----
// ---------------------------------------------------------------------------
// bcc_datapath
// Configuration registers, column state, residue arithmetic, factor window
// and output word register, driven by the sequencer's operation code.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bcc_datapath import bcc_pkg::*; #(
  parameter int MAX_SIZE  = MAX_SIZE_DEF,
  parameter int BAND      = BAND_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  op_t                    op,
  output status_t                status,
  output iter_req_t              iter_req,
  input  iter_rsp_t              iter_rsp,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  localparam logic signed [63:0] LIM     = 64'sd1 <<< (62 - FRAC_BITS);
  localparam logic signed [63:0] NEG_LIM = -LIM;

  cfg_t                     cfg_r;
  logic [SIZE_W-1:0]        j_r;
  logic [ROW_W-1:0]         d_r;
  logic                     bad_r;
  logic signed [63:0]       r_r;
  logic signed [63:0]       prod_r;
  logic signed [VAL_W-1:0]  col_r [3];
  logic signed [VAL_W-1:0]  w0_r [3];
  logic signed [VAL_W-1:0]  w1_r [3];

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r;
  logic [IDX_W-1:0]         out_col_r;
  logic [VAL_W-1:0]         out_val_r;
  logic                     out_last_r;
  logic                     out_err_r;
  logic                     out_done_r;

  logic [SIZE_W-1:0]        n;
  logic [SIZE_W-1:0]        rows_left;
  logic [ROW_W-1:0]         nrows_m1;
  logic                     col_done;
  logic                     out_free;
  logic                     out_load;
  logic                     take;

  logic [1:0]               cs;
  logic signed [12:0]       start_s, row_s, colp_s, li, lj;
  logic signed [COEF_W-1:0] coef;
  logic signed [63:0]       r_init;

  logic signed [VAL_W-1:0]  mul_a, mul_b;
  logic signed [63:0]       mul_p;
  logic signed [63:0]       prod_sh;

  logic signed [63:0]       r_sq, r_dv, sq_sh, dv_sh, dv_mag;

  assign cfg_ready = rst_n;
  assign in_tready = (op == OP_TAKE) && rst_n;
  assign take      = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = ((op == OP_EMIT) || (op == OP_EMIT_DONE)) && out_free;

  always_comb begin
    n = ({21'b0, cfg_r.matrix_size} > 32'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : cfg_r.matrix_size;
    col_done  = (j_r >= n);
    rows_left = n - j_r;
    nrows_m1  = (rows_left >= SIZE_W'(BAND)) ? ROW_W'(BAND - 1) : (rows_left[ROW_W-1:0] - 2'd1);
  end

  always_comb begin
    cs      = (cfg_r.corner_size > 2'd2) ? 2'd2 : cfg_r.corner_size;
    start_s = signed'({2'b00, n}) - signed'({11'b0, cs});
    row_s   = signed'({2'b00, j_r}) + signed'({11'b0, d_r});
    colp_s  = signed'({2'b00, j_r});
    li      = row_s - start_s;
    lj      = colp_s - start_s;
    if (cs != 2'd0 && colp_s >= start_s) begin
      if (li == 13'sd0 && lj == 13'sd0) begin
        coef = cfg_r.corner_first_diag;
      end else if (li == 13'sd1 && lj == 13'sd1) begin
        coef = cfg_r.corner_second_diag;
      end else begin
        coef = cfg_r.corner_off;
      end
    end else begin
      case (d_r)
        2'd0:    coef = cfg_r.coef_diag;
        2'd1:    coef = cfg_r.coef_off_one;
        default: coef = cfg_r.coef_off_two;
      endcase
    end
    r_init = {{(64 - COEF_W){coef[COEF_W-1]}}, coef} <<< FRAC_BITS;
  end

  // Shared multiplier: window term of column j-1, then of column j-2.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (op == OP_INIT_ROW) begin
      if ((32'(d_r) + 1 < BAND) && (d_r < 2'd2)) begin
        mul_a = (d_r == 2'd0) ? w0_r[1] : w0_r[2];
        mul_b = w0_r[1];
      end
    end else if (op == OP_SUB_MUL2) begin
      if ((d_r == 2'd0) && (BAND > 2)) begin
        mul_a = w1_r[2];
        mul_b = w1_r[2];
      end
    end
    mul_p   = mul_a * mul_b;
    prod_sh = prod_r >>> FRAC_BITS;
  end

  always_comb begin
    r_sq   = (r_r > LIM) ? LIM : r_r;
    sq_sh  = r_sq <<< FRAC_BITS;
    r_dv   = (r_r > LIM) ? LIM : ((r_r < NEG_LIM) ? NEG_LIM : r_r);
    dv_sh  = r_dv <<< FRAC_BITS;
    dv_mag = dv_sh[63] ? -dv_sh : dv_sh;
    iter_req.start   = ((op == OP_START_SQRT) && (r_r > 64'sd0)) ||
                       ((op == OP_START_DIV) && !bad_r);
    iter_req.mode    = (op == OP_START_DIV) ? MODE_DIV : MODE_SQRT;
    iter_req.operand = (op == OP_START_DIV) ? dv_mag[OPND_W-1:0] : sq_sh[OPND_W-1:0];
    iter_req.neg     = dv_sh[63];
    iter_req.divisor = col_r[0];
  end

  always_comb begin
    status.in_valid    = in_tvalid;
    status.col_done    = col_done;
    status.offdiag     = (d_r != 2'd0);
    status.r_nonpos    = (r_r <= 64'sd0);
    status.bad         = bad_r;
    status.iter_busy   = iter_rsp.busy;
    status.more_rows   = (d_r != nrows_m1);
    status.emit_loop   = !out_free || (d_r != nrows_m1);
    status.out_blocked = !out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.matrix_size        <= 11'd1;
      cfg_r.coef_diag          <= 8'sd2;
      cfg_r.coef_off_one       <= '0;
      cfg_r.coef_off_two       <= '0;
      cfg_r.corner_size        <= '0;
      cfg_r.corner_first_diag  <= '0;
      cfg_r.corner_off         <= '0;
      cfg_r.corner_second_diag <= '0;
      j_r         <= '0;
      d_r         <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        w0_r[k] <= '0;
        w1_r[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MATRIX_SIZE:        cfg_r.matrix_size        <= cfg_data;
          REG_COEF_DIAG:          cfg_r.coef_diag          <= cfg_data[COEF_W-1:0];
          REG_COEF_OFF_ONE:       cfg_r.coef_off_one       <= cfg_data[COEF_W-1:0];
          REG_COEF_OFF_TWO:       cfg_r.coef_off_two       <= cfg_data[COEF_W-1:0];
          REG_CORNER_SIZE:        cfg_r.corner_size        <= cfg_data[1:0];
          REG_CORNER_FIRST_DIAG:  cfg_r.corner_first_diag  <= cfg_data[COEF_W-1:0];
          REG_CORNER_OFF:         cfg_r.corner_off         <= cfg_data[COEF_W-1:0];
          REG_CORNER_SECOND_DIAG: cfg_r.corner_second_diag <= cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (op)
        OP_TAKE: begin
          if (take && in_tdata[0]) begin
            j_r <= '0;
            for (int k = 0; k < 3; k++) begin
              w0_r[k] <= '0;
              w1_r[k] <= '0;
            end
          end
        end
        OP_START_COL: begin
          d_r   <= '0;
          bad_r <= 1'b0;
        end
        OP_START_SQRT: begin
          if (r_r <= 64'sd0) begin
            bad_r <= 1'b1;
          end
        end
        OP_NEXT_ROW:   d_r <= d_r + 2'd1;
        OP_EMIT_START: d_r <= '0;
        OP_EMIT: begin
          if (out_free) begin
            d_r <= d_r + 2'd1;
          end
        end
        OP_COL_END: begin
          j_r <= j_r + 11'd1;
          for (int k = 0; k < 3; k++) begin
            w1_r[k] <= w0_r[k];
            w0_r[k] <= col_r[k];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_START_COL: begin
        for (int k = 0; k < 3; k++) begin
          col_r[k] <= '0;
        end
      end
      OP_INIT_ROW: begin
        r_r    <= r_init;
        prod_r <= mul_p;
      end
      OP_SUB_MUL2: begin
        r_r    <= r_r - prod_sh;
        prod_r <= mul_p;
      end
      OP_SUB_FINAL: r_r <= r_r - prod_sh;
      OP_STORE_ITER: begin
        if (!iter_rsp.busy) begin
          col_r[d_r] <= iter_rsp.result;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_row_r  <= IDX_W'(j_r + {9'b0, d_r});
          out_col_r  <= j_r[IDX_W-1:0];
          out_val_r  <= col_r[d_r];
          out_last_r <= (d_r == nrows_m1);
          out_err_r  <= bad_r;
          out_done_r <= 1'b0;
        end
      end
      OP_EMIT_DONE: begin
        if (out_free) begin
          out_row_r  <= '0;
          out_col_r  <= '0;
          out_val_r  <= '0;
          out_last_r <= 1'b1;
          out_err_r  <= 1'b0;
          out_done_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_val_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_done_r, out_err_r};

  `BCC_ASSERT(a_pivot_pos, clk, rst_n, (op == OP_EMIT) && !bad_r |-> (col_r[0] > 32'sd0), "good column with non-positive pivot")
  `BCC_ASSERT(a_err_zero, clk, rst_n, out_valid_r && out_err_r |-> (out_val_r == '0), "pivot error word carries nonzero value")

endmodule

// ----- dv/banded_cholesky_column_engine_top_tb.sv -----
// ---------------------------------------------------------------------------
// banded_cholesky_column_engine_top_tb
// Self-checking bench for the banded Cholesky column engine. A table of
// directed words (reset values, size and coefficient extremes, bad pivots,
// corner blocks, oversized matrices) runs first. Then random factorizations
// run under several sender and receiver idle patterns. Every factor word is
// compared with a fixed-point column predictor kept in step with each
// accepted input word and register write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module banded_cholesky_column_engine_top_tb;
  import bcc_pkg::*;

  localparam int     FB          = FRAC_BITS_DEF;
  localparam longint RES_LIM     = longint'(1) << (62 - FB);
  localparam longint I32_MAX     = 64'sd2147483647;
  localparam longint I32_MIN     = -64'sd2147483648;
  localparam int     LIMIT       = 400000;
  localparam int     HOLD_CYCLES = 1500;
  localparam int     SETTLE      = 200;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    pivot_err;
    logic                    done;
  } factor_word_t;

  typedef struct {
    bit           is_cfg;
    cfg_reg_t     reg_idx;
    logic [10:0]  reg_val;
    logic         restart;
    bit           typed;
    factor_word_t first;
  } plan_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  cfg_reg_t               cfg_index  = REG_MATRIX_SIZE;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // predictor copy of the registers and column state
  logic [SIZE_W-1:0] m_size   = 11'd1;
  int                m_diag   = 2;
  int                m_off1   = 0;
  int                m_off2   = 0;
  logic [1:0]        m_corner = 2'd0;
  int                m_cfd    = 0;
  int                m_coff   = 0;
  int                m_csd    = 0;
  logic [SIZE_W-1:0] col_count = '0;
  int                win_prev[3]  = '{0, 0, 0};
  int                win_prev2[3] = '{0, 0, 0};

  factor_word_t pending_factors[$];
  plan_row_t    plan[$];

  int err_count   = 0;
  int words_in    = 0;
  int words_out   = 0;
  int cfg_writes  = 0;
  int pivot_seen  = 0;
  int done_seen   = 0;
  int cycle_count = 0;
  int idle_mode   = 0;
  int hold_token  = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  banded_cholesky_column_engine_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint floor_prod(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FB;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned rt, trial;
    rt = 0;
    for (int k = 31; k >= 0; k--) begin
      trial = rt | (64'd1 << k);
      if (trial * trial <= x) rt = trial;
    end
    return rt;
  endfunction

  function automatic int clip32(longint v);
    if (v > I32_MAX) return int'(I32_MAX);
    if (v < I32_MIN) return int'(I32_MIN);
    return int'(v);
  endfunction

  function automatic int band_coef(int i, int j, int n);
    int cs, base;
    cs = (m_corner > 2'd2) ? 2 : int'(m_corner);
    base = n - cs;
    if (cs > 0 && i >= base && j >= base) begin
      if (i == base && j == base) return m_cfd;
      if (i == base + 1 && j == base + 1) return m_csd;
      return m_coff;
    end
    case (i - j)
      0: return m_diag;
      1: return m_off1;
      default: return m_off2;
    endcase
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, logic [10:0] val);
    case (idx)
      REG_MATRIX_SIZE:        m_size   = val;
      REG_COEF_DIAG:          m_diag   = int'($signed(val[7:0]));
      REG_COEF_OFF_ONE:       m_off1   = int'($signed(val[7:0]));
      REG_COEF_OFF_TWO:       m_off2   = int'($signed(val[7:0]));
      REG_CORNER_SIZE:        m_corner = val[1:0];
      REG_CORNER_FIRST_DIAG:  m_cfd    = int'($signed(val[7:0]));
      REG_CORNER_OFF:         m_coff   = int'($signed(val[7:0]));
      REG_CORNER_SECOND_DIAG: m_csd    = int'($signed(val[7:0]));
      default: ;
    endcase
  endfunction

  task automatic predict_column(input logic restart_bit, output factor_word_t first_w);
    int n, j, rows, piv;
    int colv[3];
    longint r, q;
    longint unsigned rad;
    logic bad;
    factor_word_t w;
    n = (m_size > SIZE_W'(MAX_SIZE_DEF)) ? MAX_SIZE_DEF : int'(m_size);
    if (restart_bit) begin
      col_count = '0;
      win_prev  = '{0, 0, 0};
      win_prev2 = '{0, 0, 0};
    end
    j = int'(col_count);
    if (j >= n) begin
      w = '{row: '0, col: '0, value: '0, last: 1'b1, pivot_err: 1'b0, done: 1'b1};
      pending_factors.push_back(w);
      first_w = w;
      return;
    end
    rows = (n - j > 3) ? 3 : n - j;
    colv = '{0, 0, 0};
    bad = 1'b0;
    piv = 0;
    for (int d = 0; d < rows; d++) begin
      r = longint'(band_coef(j + d, j, n)) * (longint'(1) << FB);
      if (j >= 1 && d <= 1) r -= floor_prod(win_prev[d + 1], win_prev[1]);
      if (j >= 2 && d == 0) r -= floor_prod(win_prev2[2], win_prev2[2]);
      if (d == 0) begin
        if (r <= 0) begin
          bad = 1'b1;
          colv[0] = 0;
        end else begin
          if (r > RES_LIM) r = RES_LIM;
          rad = r;
          rad = root_floor(rad << FB);
          if (rad > 64'h7FFF_FFFF) colv[0] = int'(I32_MAX);
          else colv[0] = int'(rad);
        end
        piv = colv[0];
      end else if (bad || piv <= 0) begin
        colv[d] = 0;
      end else begin
        if (r > RES_LIM) r = RES_LIM;
        if (r < -RES_LIM) r = -RES_LIM;
        q = (r * (longint'(1) << FB)) / longint'(piv);
        colv[d] = clip32(q);
      end
    end
    for (int d = 0; d < rows; d++) begin
      w.row       = IDX_W'(j + d);
      w.col       = IDX_W'(j);
      w.value     = colv[d];
      w.last      = (d == rows - 1);
      w.pivot_err = bad;
      w.done      = 1'b0;
      pending_factors.push_back(w);
      if (d == 0) first_w = w;
    end
    win_prev2 = win_prev;
    win_prev  = colv;
    col_count = col_count + 1'b1;
  endtask

  function automatic bit send_gap();
    if (idle_mode == 1) return $urandom_range(0, 99) < 75;
    if (idle_mode == 3) return $urandom_range(0, 99) < 9;
    return 1'b0;
  endfunction

  function automatic bit recv_stall();
    if (idle_mode == 2) return $urandom_range(0, 99) < 75;
    if (idle_mode == 3) return $urandom_range(0, 99) < 9;
    return 1'b0;
  endfunction

  function automatic logic [10:0] rand_coef(int lo, int hi);
    int v;
    v = lo + int'($urandom_range(0, hi - lo));
    return {3'($urandom_range(0, 7)), 8'(v)};
  endfunction

  function automatic void plan_cfg(cfg_reg_t idx, logic [10:0] val);
    plan_row_t p;
    p = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, restart: 1'b0, typed: 1'b0, first: '0};
    plan.push_back(p);
  endfunction

  function automatic void plan_word(logic rs);
    plan_row_t p;
    p = '{is_cfg: 1'b0, reg_idx: REG_MATRIX_SIZE, reg_val: '0, restart: rs, typed: 1'b0,
          first: '0};
    plan.push_back(p);
  endfunction

  function automatic void plan_typed(logic rs, logic [31:0] val, logic last, logic err,
                                     logic done);
    plan_row_t p;
    p = '{is_cfg: 1'b0, reg_idx: REG_MATRIX_SIZE, reg_val: '0, restart: rs, typed: 1'b1,
          first: '{row: '0, col: '0, value: val, last: last, pivot_err: err, done: done}};
    plan.push_back(p);
  endfunction

  function automatic void check_word();
    factor_word_t got, want;
    got.row       = out_tdata[9:0];
    got.col       = out_tdata[19:10];
    got.value     = out_tdata[51:20];
    got.last      = out_tlast;
    got.pivot_err = out_tuser[0];
    got.done      = out_tuser[1];
    words_out++;
    if (got.pivot_err) pivot_seen++;
    if (got.done) done_seen++;
    if (pending_factors.size() == 0) begin
      err_count++;
      if (err_count < 40)
        $display("%0t: unexpected factor word row %0d col %0d value %0d", $time,
                 got.row, got.col, got.value);
      return;
    end
    want = pending_factors.pop_front();
    if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
        got.last !== want.last || got.pivot_err !== want.pivot_err ||
        got.done !== want.done) begin
      err_count++;
      if (err_count < 40)
        $display("%0t: mismatch expected row %0d col %0d value %0d last %0b err %0b done %0b",
                 $time, want.row, want.col, want.value, want.last, want.pivot_err,
                 want.done, " / actual row %0d col %0d value %0d last %0b err %0b done %0b",
                 got.row, got.col, got.value, got.last, got.pivot_err, got.done);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_word();
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !recv_stall();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d factor words outstanding", cycle_count,
               pending_factors.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    apply_reg(idx, val);
  endtask

  task automatic send_word(input logic restart_bit, output factor_word_t first_w);
    while (send_gap()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart_bit};
    do @(posedge clk); while (!in_tready);
    words_in++;
    predict_column(restart_bit, first_w);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_factors.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent, run_len, size_v, dg, pick;
    bit healthy;
    factor_word_t first_w;

    // reset values, then past the end
    plan_typed(1'b1, 32'd92681, 1'b1, 1'b0, 1'b0);
    plan_typed(1'b0, 32'd0, 1'b1, 1'b0, 1'b1);
    plan_cfg(REG_MATRIX_SIZE, 11'd0);
    plan_typed(1'b1, 32'd0, 1'b1, 1'b0, 1'b1);
    // bad pivots: most negative and zero diagonal
    plan_cfg(REG_MATRIX_SIZE, 11'd3);
    plan_cfg(REG_COEF_DIAG, 11'h080);
    plan_typed(1'b1, 32'd0, 1'b0, 1'b1, 1'b0);
    plan_cfg(REG_COEF_DIAG, 11'h000);
    plan_typed(1'b1, 32'd0, 1'b0, 1'b1, 1'b0);
    plan_cfg(REG_COEF_DIAG, 11'd4);
    plan_cfg(REG_MATRIX_SIZE, 11'd1);
    plan_typed(1'b1, 32'h0002_0000, 1'b1, 1'b0, 1'b0);
    // pentadiagonal 1, -4, 6 over five columns and one past the end
    plan_cfg(REG_MATRIX_SIZE, 11'd5);
    plan_cfg(REG_COEF_DIAG, 11'd6);
    plan_cfg(REG_COEF_OFF_ONE, 11'h7FC);
    plan_cfg(REG_COEF_OFF_TWO, 11'd1);
    plan_word(1'b1);
    repeat (4) plan_word(1'b0);
    plan_typed(1'b0, 32'd0, 1'b1, 1'b0, 1'b1);
    // largest coefficients, restart mid-factorization
    plan_cfg(REG_MATRIX_SIZE, 11'd4);
    plan_cfg(REG_COEF_DIAG, 11'h07F);
    plan_cfg(REG_COEF_OFF_ONE, 11'h07F);
    plan_cfg(REG_COEF_OFF_TWO, 11'h07F);
    plan_word(1'b1);
    plan_word(1'b0);
    plan_word(1'b0);
    plan_word(1'b1);
    // most negative off-diagonals
    plan_cfg(REG_MATRIX_SIZE, 11'd3);
    plan_cfg(REG_COEF_OFF_ONE, 11'h080);
    plan_cfg(REG_COEF_OFF_TWO, 11'h080);
    repeat (3) plan_word(1'b0);
    // two-row corner with extreme entries
    plan_cfg(REG_COEF_DIAG, 11'd6);
    plan_cfg(REG_COEF_OFF_ONE, 11'h7FD);
    plan_cfg(REG_COEF_OFF_TWO, 11'd0);
    plan_cfg(REG_CORNER_SIZE, 11'd2);
    plan_cfg(REG_CORNER_FIRST_DIAG, 11'h07F);
    plan_cfg(REG_CORNER_OFF, 11'h080);
    plan_cfg(REG_CORNER_SECOND_DIAG, 11'h07F);
    plan_word(1'b1);
    plan_word(1'b0);
    plan_word(1'b0);
    // corner size three on a one-row matrix: corner overhangs the top
    plan_cfg(REG_CORNER_SIZE, 11'd3);
    plan_cfg(REG_MATRIX_SIZE, 11'd1);
    plan_cfg(REG_CORNER_SECOND_DIAG, 11'd2);
    plan_word(1'b1);
    // oversized matrix clamps to the maximum
    plan_cfg(REG_MATRIX_SIZE, 11'h7FF);
    plan_cfg(REG_CORNER_SIZE, 11'd1);
    plan_cfg(REG_COEF_DIAG, 11'd4);
    plan_cfg(REG_COEF_OFF_ONE, 11'd1);
    plan_word(1'b1);
    plan_word(1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < plan.size(); k++) begin
      if (plan[k].is_cfg) begin
        if (k == 0 || !plan[k-1].is_cfg) settle();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
        if (k + 1 == plan.size() || !plan[k+1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        send_word(plan[k].restart, first_w);
        if (plan[k].typed && first_w !== plan[k].first) begin
          err_count++;
          $display("%0t: table row %0d expected value %0d err %0b done %0b, predicted %0d %0b %0b",
                   $time, k, plan[k].first.value, plan[k].first.pivot_err,
                   plan[k].first.done, first_w.value, first_w.pivot_err, first_w.done);
        end
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      idle_mode = ph % 4;
      healthy = $urandom_range(0, 9) < 7;
      pick = $urandom_range(0, 99);
      if (pick < 4) size_v = 0;
      else if (pick < 9) size_v = $urandom_range(1000, 2047);
      else size_v = $urandom_range(1, 12);
      dg = healthy ? int'($urandom_range(8, 127)) : int'($urandom_range(0, 255)) - 128;
      write_reg(REG_MATRIX_SIZE, 11'(size_v));
      write_reg(REG_COEF_DIAG, rand_coef(dg, dg));
      write_reg(REG_COEF_OFF_ONE, healthy ? rand_coef(-dg / 3, dg / 3) : rand_coef(-128, 127));
      write_reg(REG_COEF_OFF_TWO, healthy ? rand_coef(-dg / 4, dg / 4) : rand_coef(-128, 127));
      write_reg(REG_CORNER_SIZE, 11'($urandom_range(0, 2047)));
      write_reg(REG_CORNER_FIRST_DIAG, healthy ? rand_coef(dg / 2, 127) : rand_coef(-128, 127));
      write_reg(REG_CORNER_OFF, healthy ? rand_coef(-dg / 4, dg / 4) : rand_coef(-128, 127));
      write_reg(REG_CORNER_SECOND_DIAG, healthy ? rand_coef(dg / 2, 127) : rand_coef(-128, 127));
      cfg_valid <= 1'b0;
      // stall the result side long enough to back up the input
      if (ph == 5) hold_token++;
      sent = 0;
      while (sent < 25) begin
        run_len = (size_v == 0 || size_v > 12) ? int'($urandom_range(2, 10)) : size_v;
        send_word(1'b1, first_w);
        sent++;
        for (int c = 1; c < run_len; c++) begin
          send_word($urandom_range(0, 19) == 0, first_w);
          sent++;
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            send_word(1'b0, first_w);
            sent++;
          end
        end
      end
    end

    settle();
    repeat (SETTLE) @(posedge clk);
    $display("drove %0d input words and %0d register writes in %0d cycles",
             words_in, cfg_writes, cycle_count);
    $display("checked %0d factor words: %0d with pivot error, %0d past the end",
             words_out, pivot_seen, done_seen);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
